### rtl/bsp_point_locate_core_defines.svh
// ----------------------------------------------------------------------------
// bsp point locate assertion macros
// shared property forms for the checker, sampled on clk, reset on rst
// ----------------------------------------------------------------------------
`ifndef BSP_POINT_LOCATE_CORE_DEFINES_SVH
`define BSP_POINT_LOCATE_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define BPL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define BPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// state right after a reset cycle
`define BPL_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

### rtl/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg
// shared widths, codes, types and helpers of the bsp point locate block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpl_pkg;

  // default sizes
  localparam int MAX_NODES_DEF = 4096;
  localparam int MAX_STEPS_DEF = 64;

  // field widths
  localparam int CNT_W   = 13;
  localparam int IDX_W   = 12;
  localparam int COORD_W = 16;
  localparam int LINK_W  = 16;
  localparam int POINT_W = 32;
  localparam int SUB_W   = 15;
  localparam int PROD_W  = 48;

  // wide enough for any node count up to the largest table
  localparam int COUNT_W = 16;

  // reciprocal scale for link reduction
  localparam int RECIP_SHIFT = 30;

  // request codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOCATE = 1'b1;

  // one partition line as stored in the lines memory
  typedef struct packed {
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] ox;
  } line_t;

  // child links as stored in the links memory
  typedef struct packed {
    logic [LINK_W-1:0] back;
    logic [LINK_W-1:0] front;
  } links_t;

  // stage load strobes for the per-level datapath
  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } stage_ctrl_t;

  // address width for a table of the given depth
  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

### rtl/bpl_if.sv
// ----------------------------------------------------------------------------
// bpl interfaces
// request, result and node count write channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// request channel: node load or point locate
interface bpl_req_if
  import bpl_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic        [IDX_W-1:0]   node_index;
  logic signed [COORD_W-1:0] line_origin_x;
  logic signed [COORD_W-1:0] line_origin_y;
  logic signed [COORD_W-1:0] line_delta_x;
  logic signed [COORD_W-1:0] line_delta_y;
  logic        [LINK_W-1:0]  child_front;
  logic        [LINK_W-1:0]  child_back;
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;

  modport source (
    output valid, cmd, node_index, line_origin_x, line_origin_y,
           line_delta_x, line_delta_y, child_front, child_back, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, cmd, node_index, line_origin_x, line_origin_y,
           line_delta_x, line_delta_y, child_front, child_back, point_x, point_y,
    output ready
  );
endinterface

// result channel: located leaf
interface bpl_res_if
  import bpl_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [SUB_W-1:0] subsector;
  logic             step_limit_hit;

  modport source (output valid, subsector, step_limit_hit, input ready);
  modport sink (input valid, subsector, step_limit_hit, output ready);
endinterface

// node count write channel
interface bpl_cfg_if
  import bpl_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/bsp_point_locate_core.sv
// ----------------------------------------------------------------------------
// bsp_point_locate_core
// a load request leaves the block idle, so it is ready again the next cycle
// a locate walks from the root one level at a time to a leaf or the step bound;
// an empty table gives leaf zero with no walk; each level is one node memory read
// followed by the two registered stages of the side test and link reduction
// reset clears the node count and the walk control; node memories keep content
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsp_point_locate_core
  import bpl_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input logic       clk,
  input logic       rst,
  bpl_req_if.sink   req,
  bpl_res_if.source res,
  bpl_cfg_if.sink   cfg
);

  localparam int ADDR_W = addr_w(MAX_NODES);
  localparam int STEP_W = $clog2(MAX_STEPS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EMPTY = 3'd1;
  localparam logic [2:0] S_P1    = 3'd2;
  localparam logic [2:0] S_P2    = 3'd3;
  localparam logic [2:0] S_P3    = 3'd4;

  logic [2:0]                state;
  logic [CNT_W-1:0]          node_count;
  logic [STEP_W-1:0]         steps;
  logic [STEP_W-1:0]         steps_next;
  logic signed [POINT_W-1:0] px;
  logic signed [POINT_W-1:0] py;

  logic                      out_valid;
  logic [SUB_W-1:0]          out_subsector;
  logic                      out_hit;
  logic                      out_free;

  logic [COUNT_W-1:0]        count_ext;
  logic [COUNT_W-1:0]        count_clamped;
  logic [COUNT_W-1:0]        root;
  logic [COUNT_W-1:0]        slot_ext;
  logic                      req_fire;
  logic                      mem_we;

  line_t                     line_w;
  links_t                    links_w;
  logic [$bits(line_t)-1:0]  lines_rdata;
  logic [$bits(links_t)-1:0] links_rdata;
  line_t                     line_rd;
  links_t                    links_rd;
  logic [ADDR_W-1:0]         raddr;

  stage_ctrl_t               ctrl;
  logic                      side;
  logic                      front_leaf;
  logic                      back_leaf;
  logic [SUB_W-1:0]          front_value;
  logic [SUB_W-1:0]          back_value;
  logic [ADDR_W-1:0]         front_idx;
  logic [ADDR_W-1:0]         back_idx;
  logic                      sel_leaf;
  logic [SUB_W-1:0]          sel_value;
  logic [ADDR_W-1:0]         next_addr;
  logic                      limit;

  // handshakes
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign out_free  = !out_valid || res.ready;

  assign res.valid          = out_valid;
  assign res.subsector      = out_subsector;
  assign res.step_limit_hit = out_hit;

  // root is the last node in use, count clamped to the table size
  assign count_ext     = COUNT_W'(node_count);
  assign count_clamped = (count_ext > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                           : count_ext;
  assign root          = count_clamped - COUNT_W'(1);

  // node load
  assign slot_ext = COUNT_W'(req.node_index);
  assign mem_we   = req_fire && (req.cmd == CMD_LOAD) &&
                    (slot_ext < COUNT_W'(MAX_NODES));

  always_comb begin
    line_w.ox      = req.line_origin_x;
    line_w.oy      = req.line_origin_y;
    line_w.dx      = req.line_delta_x;
    line_w.dy      = req.line_delta_y;
    links_w.front  = req.child_front;
    links_w.back   = req.child_back;
  end

  // read the root on entry, the chosen child at the end of each level
  assign raddr = (state == S_IDLE) ? root[ADDR_W-1:0] : next_addr;

  bpl_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (MAX_NODES)
  ) u_lines (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_ext[ADDR_W-1:0]),
    .wdata (line_w),
    .raddr (raddr),
    .rdata (lines_rdata)
  );

  bpl_ram #(
    .WIDTH ($bits(links_t)),
    .DEPTH (MAX_NODES)
  ) u_links (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_ext[ADDR_W-1:0]),
    .wdata (links_w),
    .raddr (raddr),
    .rdata (links_rdata)
  );

  assign line_rd  = lines_rdata;
  assign links_rd = links_rdata;

  // per-level datapath stages
  assign ctrl.s1_load = (state == S_P1);
  assign ctrl.s2_load = (state == S_P2);

  bpl_side u_side (
    .clk  (clk),
    .ctrl (ctrl),
    .px   (px),
    .py   (py),
    .line (line_rd),
    .side (side)
  );

  bpl_link #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .clk   (clk),
    .ctrl  (ctrl),
    .link  (links_rd.front),
    .leaf  (front_leaf),
    .value (front_value),
    .idx   (front_idx)
  );

  bpl_link #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk   (clk),
    .ctrl  (ctrl),
    .link  (links_rd.back),
    .leaf  (back_leaf),
    .value (back_value),
    .idx   (back_idx)
  );

  // pick the child on the decided side
  assign sel_leaf   = side ? back_leaf : front_leaf;
  assign sel_value  = side ? back_value : front_value;
  assign next_addr  = side ? back_idx : front_idx;
  assign steps_next = steps + STEP_W'(1);
  assign limit      = (steps_next >= STEP_W'(MAX_STEPS));

  // point capture
  always_ff @(posedge clk) begin
    if (req_fire && (req.cmd == CMD_LOCATE)) begin
      px <= req.point_x;
      py <= req.point_y;
    end
  end

  // walk control, node count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= '0;
      steps      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        node_count <= cfg.data;
      end
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire && (req.cmd == CMD_LOCATE)) begin
            steps <= '0;
            state <= (count_clamped == '0) ? S_EMPTY : S_P1;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_P1: begin
          state <= S_P2;
        end
        S_P2: begin
          state <= S_P3;
        end
        S_P3: begin
          if (sel_leaf || limit) begin
            if (out_free) begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            steps <= steps_next;
            state <= S_P1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if ((state == S_EMPTY) && out_free) begin
      out_subsector <= '0;
      out_hit       <= 1'b0;
    end else if ((state == S_P3) && (sel_leaf || limit) && out_free) begin
      out_subsector <= sel_leaf ? sel_value : '0;
      out_hit       <= !sel_leaf;
    end
  end

endmodule

### rtl/bpl_ram.sv
// ----------------------------------------------------------------------------
// bpl_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpl_ram
  import bpl_pkg::*;
#(
  parameter int WIDTH = $bits(line_t),
  parameter int DEPTH = MAX_NODES_DEF,
  localparam int AW = addr_w(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/bpl_side.sv
// ----------------------------------------------------------------------------
// bpl_side
// two stage side test of a 16.16 point against one partition line
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpl_side
  import bpl_pkg::*;
(
  input  logic                      clk,
  input  stage_ctrl_t               ctrl,
  input  logic signed [POINT_W-1:0] px,
  input  logic signed [POINT_W-1:0] py,
  input  line_t                     line,
  output logic                      side
);

  logic signed [POINT_W-1:0] ox_fix;
  logic signed [POINT_W-1:0] oy_fix;
  logic signed [POINT_W-1:0] ux_c;
  logic signed [POINT_W-1:0] uy_c;
  logic                      quick_c;
  logic                      quick_side_c;

  logic                      s1_quick;
  logic                      s1_quick_side;
  logic signed [POINT_W-1:0] s1_ux;
  logic signed [POINT_W-1:0] s1_uy;
  logic signed [COORD_W-1:0] s1_ldx;
  logic signed [COORD_W-1:0] s1_ldy;

  logic signed [PROD_W-1:0]  p_left_c;
  logic signed [PROD_W-1:0]  p_right_c;
  logic                      s2_quick;
  logic                      s2_quick_side;
  logic signed [PROD_W-1:0]  s2_left;
  logic signed [PROD_W-1:0]  s2_right;
  logic signed [POINT_W-1:0] f_left;
  logic signed [POINT_W-1:0] f_right;

  // origin in 16.16 and wrapped offsets of the point
  assign ox_fix = $signed({line.ox, 16'h0000});
  assign oy_fix = $signed({line.oy, 16'h0000});
  assign ux_c   = px - ox_fix;
  assign uy_c   = py - oy_fix;

  // axis aligned lines and sign disagreement settle the side at once
  always_comb begin
    quick_c      = 1'b1;
    quick_side_c = 1'b0;
    priority if (line.dx == '0) begin
      quick_side_c = (px <= ox_fix) ? (line.dy > 0) : (line.dy < 0);
    end else if (line.dy == '0) begin
      quick_side_c = (py <= oy_fix) ? (line.dx < 0) : (line.dx > 0);
    end else if (line.dy[COORD_W-1] ^ line.dx[COORD_W-1] ^ ux_c[POINT_W-1]
                 ^ uy_c[POINT_W-1]) begin
      quick_side_c = line.dy[COORD_W-1] ^ ux_c[POINT_W-1];
    end else begin
      quick_c = 1'b0;
    end
  end

  // stage 1 register
  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      s1_quick      <= quick_c;
      s1_quick_side <= quick_side_c;
      s1_ux         <= ux_c;
      s1_uy         <= uy_c;
      s1_ldx        <= line.dx;
      s1_ldy        <= line.dy;
    end
  end

  // cross products
  assign p_left_c  = PROD_W'(s1_uy) * PROD_W'(s1_ldx);
  assign p_right_c = PROD_W'(s1_ldy) * PROD_W'(s1_ux);

  // stage 2 register
  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      s2_quick      <= s1_quick;
      s2_quick_side <= s1_quick_side;
      s2_left       <= p_left_c;
      s2_right      <= p_right_c;
    end
  end

  // floor of product / 2^16, then compare
  assign f_left  = $signed(s2_left[PROD_W-1:16]);
  assign f_right = $signed(s2_right[PROD_W-1:16]);
  assign side    = s2_quick ? s2_quick_side : !(f_left < f_right);

endmodule

### rtl/bpl_link.sv
// ----------------------------------------------------------------------------
// bpl_link
// two stage split of a child link into leaf flag, leaf index and table slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpl_link
  import bpl_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  localparam int ADDR_W = addr_w(MAX_NODES)
) (
  input  logic              clk,
  input  stage_ctrl_t       ctrl,
  input  logic [LINK_W-1:0] link,
  output logic              leaf,
  output logic [SUB_W-1:0]  value,
  output logic [ADDR_W-1:0] idx
);

  localparam longint RECIP   = (64'd1 << RECIP_SHIFT) / MAX_NODES;
  localparam int     RECIP_W = RECIP_SHIFT + 1;
  localparam int     MP_W    = SUB_W + RECIP_W;
  localparam int     Q_W     = SUB_W + 1;
  localparam int     QN_W    = 2 * COUNT_W;
  localparam int     R_W     = COUNT_W + 1;

  logic [MP_W-1:0]   prod_c;
  logic              a_leaf;
  logic [SUB_W-1:0]  a_value;
  logic [MP_W-1:0]   a_prod;

  logic [Q_W-1:0]    quot_c;
  logic [QN_W-1:0]   rem_wide_c;
  logic              b_leaf;
  logic [SUB_W-1:0]  b_value;
  logic [R_W-1:0]    b_rem;

  // quotient estimate by reciprocal multiply
  assign prod_c = MP_W'(link[SUB_W-1:0]) * MP_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      a_leaf  <= link[LINK_W-1];
      a_value <= link[SUB_W-1:0];
      a_prod  <= prod_c;
    end
  end

  // remainder, at most one table size too large
  assign quot_c     = Q_W'(a_prod >> RECIP_SHIFT);
  assign rem_wide_c = QN_W'(a_value) - QN_W'(quot_c) * QN_W'(MAX_NODES);

  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      b_leaf  <= a_leaf;
      b_value <= a_value;
      b_rem   <= rem_wide_c[R_W-1:0];
    end
  end

  // final correction
  assign leaf  = b_leaf;
  assign value = b_value;
  assign idx   = (b_rem >= R_W'(MAX_NODES)) ? ADDR_W'(b_rem - R_W'(MAX_NODES))
                                             : ADDR_W'(b_rem);

endmodule

### rtl/bpl_checker.sv
// ----------------------------------------------------------------------------
// bpl_checker
// port level checks of the bsp point locate core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bsp_point_locate_core_defines.svh"

module bpl_checker
  import bpl_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             req_cmd,
  input logic             res_valid,
  input logic             res_ready,
  input logic [SUB_W-1:0] res_subsector,
  input logic             res_step_limit_hit
);

  // a stalled result holds
  `BPL_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_subsector) && $stable(res_step_limit_hit), "result changed while stalled")

  // a walk cut off at the step bound reports leaf zero
  `BPL_ASSERT_SAME(a_hit_zero, res_valid && res_step_limit_hit, res_subsector == '0, "step limit result with nonzero leaf")

  // a locate request occupies the block
  `BPL_ASSERT_NEXT(a_locate_busy, req_valid && req_ready && req_cmd == CMD_LOCATE, !req_ready, "ready right after a locate request")

  // a load request leaves the block free
  `BPL_ASSERT_NEXT(a_load_free, req_valid && req_ready && req_cmd == CMD_LOAD, req_ready, "not ready after a load request")

  // reset leaves no result and an idle block
  `BPL_ASSERT_AFTER_RESET(a_reset_quiet, !res_valid && req_ready, "result or busy after reset")

endmodule

bind bsp_point_locate_core bpl_checker u_bpl_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .req_cmd            (req.cmd),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_subsector      (res.subsector),
  .res_step_limit_hit (res.step_limit_hit)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// bsp point locate testbench
// loads partition trees into the node table, walks points down them and checks
// every located leaf against a behavioral walk kept inside the bench or a fixed
// expected leaf; a short table of directed requests comes first, then random
// trees, deep chains that straddle the step bound and node counts past the table
// size, under several handshake idling patterns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import bpl_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int SETTLE_WAIT  = 200;
  localparam int REQ_TARGET   = 1600;
  localparam int LOAD_SETTLE  = 4;

  typedef enum logic [1:0] {ROW_LOAD, ROW_LOCATE, ROW_COUNT} row_kind_t;

  typedef struct packed {
    logic                cmd;
    logic [IDX_W-1:0]    node_index;
    logic [COORD_W-1:0]  line_origin_x;
    logic [COORD_W-1:0]  line_origin_y;
    logic [COORD_W-1:0]  line_delta_x;
    logic [COORD_W-1:0]  line_delta_y;
    logic [LINK_W-1:0]   child_front;
    logic [LINK_W-1:0]   child_back;
    logic [POINT_W-1:0]  point_x;
    logic [POINT_W-1:0]  point_y;
  } bsp_request_t;

  typedef struct packed {
    logic [SUB_W-1:0] subsector;
    logic             step_limit_hit;
  } leaf_result_t;

  typedef struct {
    row_kind_t        kind;
    bsp_request_t     request;
    logic [CNT_W-1:0] count;
    bit               fixed;
    leaf_result_t     want;
  } directed_row_t;

  logic clk;
  logic rst = 1'b1;

  bpl_req_if req_ch ();
  bpl_res_if res_ch ();
  bpl_cfg_if cfg_ch ();

  bsp_point_locate_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // mirror of the node table and count register
  line_t            line_mirror [MAX_NODES_DEF];
  links_t           link_mirror [MAX_NODES_DEF];
  logic [CNT_W-1:0] node_count_mirror = '0;

  leaf_result_t  expected_leaves [$];
  directed_row_t directed_rows [$];
  int unsigned   tree_slots [$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int requests_sent   = 0;
  int mismatch_count  = 0;
  int quiet_cycles    = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // side of a partition line for a 16.16 point: 0 front, 1 back
  function automatic logic line_side(logic signed [31:0] px, logic signed [31:0] py,
                                     line_t ln);
    longint     ox_fx, oy_fx, dist_x, dist_y, lhs, rhs;
    logic [31:0] ux, uy;
    ox_fx = longint'(ln.ox) * 65536;
    oy_fx = longint'(ln.oy) * 65536;
    // axis aligned lines settle on one compare
    if (ln.dx == 0)
      return (longint'(px) <= ox_fx) ? (ln.dy > 0) : (ln.dy < 0);
    if (ln.dy == 0)
      return (longint'(py) <= oy_fx) ? (ln.dx < 0) : (ln.dx > 0);
    ux = px - {ln.ox, 16'h0000};
    uy = py - {ln.oy, 16'h0000};
    // disagreeing signs settle it at once
    if (ln.dy[15] ^ ln.dx[15] ^ ux[31] ^ uy[31])
      return ln.dy[15] ^ ux[31];
    // floor-rounded 16.16 cross products
    dist_x = longint'(signed'(ux));
    dist_y = longint'(signed'(uy));
    lhs = (dist_y * longint'(ln.dx)) >>> 16;
    rhs = (longint'(ln.dy) * dist_x) >>> 16;
    return (lhs < rhs) ? 1'b0 : 1'b1;
  endfunction

  // walk from the root to the leaf holding the point
  function automatic leaf_result_t locate_leaf(logic [31:0] px, logic [31:0] py);
    int unsigned  span, cur, visits, idx;
    leaf_result_t leaf;
    leaf = '0;
    span = (node_count_mirror > MAX_NODES_DEF) ? MAX_NODES_DEF : node_count_mirror;
    cur = 0;
    if (span != 0) begin
      cur = span - 1;
      visits = 0;
      while (cur[15] == 1'b0) begin
        if (visits >= MAX_STEPS_DEF) begin
          leaf.step_limit_hit = 1'b1;
          break;
        end
        idx = cur % MAX_NODES_DEF;
        cur = line_side(px, py, line_mirror[idx]) ? 32'(link_mirror[idx].back)
                                                  : 32'(link_mirror[idx].front);
        visits++;
      end
    end
    if (!leaf.step_limit_hit)
      leaf.subsector = cur[SUB_W-1:0];
    return leaf;
  endfunction

  function automatic void set_idle_mode(int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin sender_idle_pct = 59; recv_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  recv_stall_pct = 59; end
      default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endfunction

  // directed table builders
  function automatic void add_load(int slot, int ox, int oy, int dx, int dy,
                                   logic [15:0] front, logic [15:0] back);
    directed_row_t row;
    row.kind = ROW_LOAD;
    row.request = '0;
    row.count = '0;
    row.fixed = 1'b0;
    row.want = '0;
    row.request.cmd = CMD_LOAD;
    row.request.node_index = IDX_W'(slot);
    row.request.line_origin_x = 16'(ox);
    row.request.line_origin_y = 16'(oy);
    row.request.line_delta_x = 16'(dx);
    row.request.line_delta_y = 16'(dy);
    row.request.child_front = front;
    row.request.child_back = back;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_locate(logic [31:0] px, logic [31:0] py, bit fixed,
                                     logic [14:0] sub, logic hit);
    directed_row_t row;
    row.kind = ROW_LOCATE;
    row.request = '0;
    row.count = '0;
    row.request.cmd = CMD_LOCATE;
    row.request.point_x = px;
    row.request.point_y = py;
    row.fixed = fixed;
    row.want.subsector = sub;
    row.want.step_limit_hit = hit;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_count(int value);
    directed_row_t row;
    row.kind = ROW_COUNT;
    row.request = '0;
    row.count = CNT_W'(value);
    row.fixed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void build_directed();
    // empty table
    add_count(0);
    add_locate(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 15'd0, 1'b0);
    add_locate(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 15'd0, 1'b0);
    // vertical line at the far left edge
    add_load(0, -32768, 32767, 0, 32767, 16'hFFFF, 16'h8000);
    add_count(1);
    add_locate(32'h8000_0000, 32'h0000_0000, 1'b0, '0, 1'b0);
    add_locate(32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0, 1'b0);
    // horizontal line at the bottom edge
    add_load(0, 32767, -32768, -32768, 0, 16'h8001, 16'h8002);
    add_locate(32'h0000_0000, 32'h8000_0000, 1'b0, '0, 1'b0);
    add_locate(32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '0, 1'b0);
    // sloped line: sign shortcut and product compare
    add_load(0, 0, 0, 32767, -32768, 16'h8003, 16'h8004);
    add_locate(32'h0001_0000, 32'h0001_0000, 1'b0, '0, 1'b0);
    add_locate(32'h0001_0000, 32'hFFFF_0000, 1'b0, '0, 1'b0);
    add_locate(32'hFFFF_8000, 32'h0000_8000, 1'b0, '0, 1'b0);
    // node pointing at itself on both sides runs into the step bound
    add_load(0, 1, -1, -1, -1, 16'h0000, 16'h0000);
    add_locate(32'h0000_0000, 32'h0000_0000, 1'b1, 15'd0, 1'b1);
    // links past the table size wrap back into it
    add_load(0, 0, 0, 1, 1, 16'h8005, 16'h8006);
    add_load(1, 0, 0, -1, 0, 16'h7000, 16'h1000);
    add_count(2);
    add_locate(32'h0002_0000, 32'hFFFE_0000, 1'b0, '0, 1'b0);
    // counts at and past the table size use the last slot as root
    add_load(4095, -5, 7, 3, -2, 16'hF234, 16'h0001);
    add_count(8191);
    add_locate(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0, 1'b0);
    add_count(4096);
    add_locate(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0, 1'b0);
  endfunction

  // random field helpers
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 11))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom());
    endcase
  endfunction

  // leaf or a link to a slot already in this tree, sometimes aliased past the table
  function automatic logic [15:0] pick_child(int pos);
    int unsigned target;
    if (pos == 0 || $urandom_range(0, 99) < 30)
      return {1'b1, 15'($urandom())};
    if ($urandom_range(0, 99) < 5)
      target = tree_slots[$urandom_range(0, tree_slots.size() - 1)];
    else
      target = tree_slots[$urandom_range(0, pos - 1)];
    if ($urandom_range(0, 3) == 0)
      target += MAX_NODES_DEF * $urandom_range(1, 7);
    return 16'(target);
  endfunction

  function automatic logic [31:0] pick_point(logic [15:0] anchor);
    case ($urandom_range(0, 7))
      0, 1: return $urandom();
      2: return {anchor, 16'h0000};
      3: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return {anchor + 16'($urandom_range(0, 6)) - 16'd3, 16'($urandom())};
    endcase
  endfunction

  function automatic bsp_request_t make_node(int unsigned slot, int pos);
    bsp_request_t r;
    r.cmd = CMD_LOAD;
    r.node_index = IDX_W'(slot);
    r.line_origin_x = pick_coord();
    r.line_origin_y = pick_coord();
    r.line_delta_x = pick_coord();
    r.line_delta_y = pick_coord();
    r.child_front = pick_child(pos);
    r.child_back = pick_child(pos);
    r.point_x = $urandom();
    r.point_y = $urandom();
    return r;
  endfunction

  function automatic bsp_request_t make_locate();
    bsp_request_t r;
    line_t        ln;
    ln.ox = 16'($urandom());
    ln.oy = 16'($urandom());
    if (tree_slots.size() != 0)
      ln = line_mirror[tree_slots[$urandom_range(0, tree_slots.size() - 1)]];
    r.cmd = CMD_LOCATE;
    r.node_index = IDX_W'($urandom());
    r.line_origin_x = 16'($urandom());
    r.line_origin_y = 16'($urandom());
    r.line_delta_x = 16'($urandom());
    r.line_delta_y = 16'($urandom());
    r.child_front = 16'($urandom());
    r.child_back = 16'($urandom());
    r.point_x = pick_point(ln.ox);
    r.point_y = pick_point(ln.oy);
    return r;
  endfunction

  // hold requests until every located leaf has come back
  task automatic hold_until_drained();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_leaves.size() != 0) @(posedge clk);
  endtask

  task automatic send_request(input bsp_request_t r, input bit fixed,
                              input leaf_result_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.cmd <= r.cmd;
    req_ch.node_index <= r.node_index;
    req_ch.line_origin_x <= r.line_origin_x;
    req_ch.line_origin_y <= r.line_origin_y;
    req_ch.line_delta_x <= r.line_delta_x;
    req_ch.line_delta_y <= r.line_delta_y;
    req_ch.child_front <= r.child_front;
    req_ch.child_back <= r.child_back;
    req_ch.point_x <= r.point_x;
    req_ch.point_y <= r.point_y;
    do @(posedge clk); while (!req_ch.ready);
    requests_sent++;
    if (r.cmd == CMD_LOAD) begin
      line_mirror[r.node_index] = {r.line_delta_y, r.line_delta_x,
                                   r.line_origin_y, r.line_origin_x};
      link_mirror[r.node_index] = {r.child_back, r.child_front};
    end else begin
      expected_leaves.push_back(fixed ? want : locate_leaf(r.point_x, r.point_y));
    end
  endtask

  // node count is only written with the block idle
  task automatic write_node_count(input logic [CNT_W-1:0] value);
    hold_until_drained();
    repeat (LOAD_SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    node_count_mirror = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // random tree rooted at the last slot in use, then locates and reloads
  task automatic run_tree_phase(input bit hold_mid);
    int unsigned  count, root, sel, n_ops, pos;
    leaf_result_t none;
    none = '0;
    sel = $urandom_range(0, 99);
    if (sel < 3)
      count = 0;
    else if (sel < 80)
      count = $urandom_range(1, 16);
    else if (sel < 92)
      count = $urandom_range(17, MAX_NODES_DEF - 1);
    else
      count = $urandom_range(MAX_NODES_DEF, (1 << CNT_W) - 1);
    write_node_count(CNT_W'(count));
    tree_slots.delete();
    if (count != 0) begin
      root = ((count > MAX_NODES_DEF) ? MAX_NODES_DEF : count) - 1;
      repeat ($urandom_range(0, 11)) tree_slots.push_back($urandom_range(0, MAX_NODES_DEF - 1));
      tree_slots.push_back(root);
      foreach (tree_slots[i]) send_request(make_node(tree_slots[i], i), 1'b0, none);
    end
    n_ops = $urandom_range(10, 40);
    for (int k = 0; k < n_ops; k++) begin
      sel = $urandom_range(0, 99);
      if ((hold_mid && k == n_ops / 2) || sel < 2)
        hold_until_drained();
      if (sel < 8 && tree_slots.size() != 0) begin
        pos = $urandom_range(0, tree_slots.size() - 1);
        send_request(make_node(tree_slots[pos], pos), 1'b0, none);
      end else if (sel < 12) begin
        // leaf-only node anywhere keeps every walk on written slots
        send_request(make_node($urandom_range(0, MAX_NODES_DEF - 1), 0), 1'b0, none);
      end else begin
        send_request(make_locate(), 1'b0, none);
      end
    end
  endtask

  // straight chain around the step bound
  task automatic run_chain_phase();
    int unsigned  depth;
    bsp_request_t r;
    leaf_result_t none;
    none = '0;
    depth = $urandom_range(MAX_STEPS_DEF - 4, MAX_STEPS_DEF + 4);
    write_node_count(CNT_W'(depth));
    tree_slots.delete();
    for (int i = 0; i < depth; i++) begin
      tree_slots.push_back(i);
      r = make_node(i, 0);
      if (i != 0) begin
        r.child_front = 16'(i - 1);
        r.child_back = 16'(i - 1 + MAX_NODES_DEF);
      end
      send_request(r, 1'b0, none);
    end
    repeat (8) send_request(make_locate(), 1'b0, none);
  endtask

  // result ready with random stalls
  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result check against the oldest expected leaf
  always @(posedge clk) begin
    leaf_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_leaves.size() == 0) begin
        $error("unexpected result: subsector %0d step_limit_hit %0d",
               res_ch.subsector, res_ch.step_limit_hit);
        mismatch_count++;
      end else begin
        want = expected_leaves.pop_front();
        if (res_ch.subsector !== want.subsector) begin
          $error("subsector: expected %0d, actual %0d", want.subsector, res_ch.subsector);
          mismatch_count++;
        end
        if (res_ch.step_limit_hit !== want.step_limit_hit) begin
          $error("step_limit_hit: expected %0d, actual %0d",
                 want.step_limit_hit, res_ch.step_limit_hit);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    int           phase;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_LOAD;
    req_ch.node_index = '0;
    req_ch.line_origin_x = '0;
    req_ch.line_origin_y = '0;
    req_ch.line_delta_x = '0;
    req_ch.line_delta_y = '0;
    req_ch.child_front = '0;
    req_ch.child_back = '0;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    build_directed();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    set_idle_mode(0);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_COUNT)
        write_node_count(directed_rows[i].count);
      else
        send_request(directed_rows[i].request, directed_rows[i].fixed,
                     directed_rows[i].want);
    end

    // random trees under rotating idle patterns
    phase = 0;
    while (requests_sent < REQ_TARGET) begin
      set_idle_mode(phase % 4);
      if (phase % 10 == 7)
        run_chain_phase();
      else
        run_tree_phase(phase == 1);
      phase++;
    end

    hold_until_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_leaves.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bpl_pkg.sv
rtl/bpl_if.sv
rtl/bpl_ram.sv
rtl/bpl_side.sv
rtl/bpl_link.sv
rtl/bsp_point_locate_core.sv
rtl/bpl_checker.sv
bench/testbench.sv
